// ===== design/b64d_pkg.sv =====
// Package for the base64 stream decoder: sizes, result-queue types and the
// alphabet decode function. Depends on nothing; all but the checker import it.
package b64d_pkg;

    // Counted (non-whitespace) characters per text before the rest is ignored
    localparam int MAX_CHARS = 255;
    localparam int CNT_W     = $clog2(MAX_CHARS + 1);

    // Result queue: one item can give up to four results
    localparam int QDEPTH = 4;
    localparam int Q_W    = $clog2(QDEPTH + 1);
    localparam int IDX_W  = $clog2(QDEPTH);

    // Character codes with a meaning of their own
    localparam logic [7:0] CHAR_PAD   = 8'h3D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    // Status codes
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_INVALID = 1'b1;

    // One result beat
    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_status;
        logic       status_code;
        logic       last;
    } t_item;

    // Results of one decoded item, handed to the queue in one cycle
    typedef struct packed {
        logic                    valid;
        logic [Q_W-1:0]          n;
        t_item [QDEPTH-1:0]      items;
    } t_push;

    typedef struct packed {
        logic       ok;
        logic [5:0] val;
    } t_sextet;

    // Map one alphabet character to its 6-bit value
    function automatic t_sextet sextet_of(input logic [7:0] c);
        t_sextet s;
        s.ok  = 1'b1;
        s.val = 6'd0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            s.val = 6'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            s.val = 6'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            s.val = 6'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2B) begin
            s.val = 6'd62;
        end else if (c == 8'h2F) begin
            s.val = 6'd63;
        end else begin
            s.ok = 1'b0;
        end
        return s;
    endfunction

endpackage

// ===== design/base64_stream_decoder_unit.sv =====
// Base64 stream decoder: top level joining the decode core and result queue.
// Depends on b64d_pkg, b64d_core and b64d_outq.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one text character per
//   beat on i_char_code, or an end marker (i_end_marker high). Whitespace is
//   skipped; every fourth counted character completes a group, whose three
//   bytes go out once the next group starts. At the end marker the last group
//   goes out less its padding bytes, followed by one status beat
//   (o_is_status and o_last high, o_status_code 1 for invalid text).
//   Output channel (o_out_valid / i_out_ready) carries one result per beat.
//   A result passes through the input register and then the queue register
//   before it shows on the output. Throughput: one character a cycle; a beat
//   is held in the input register while the four-slot result queue lacks room
//   for its results, and an end marker that releases a whole held group (four
//   results) waits until the queue is empty.
//   Reset (synchronous, active low) empties both registers and clears the
//   group state. A stalled receiver fills the queue and then stops input.
module base64_stream_decoder_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_char_code,
    input  logic       i_end_marker,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_is_status,
    output logic       o_status_code,
    output logic       o_last
);
    import b64d_pkg::*;

    t_push          push;
    logic [Q_W-1:0] q_free;
    t_item          item;

    b64d_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_char_code  (i_char_code),
        .i_end_marker (i_end_marker),
        .i_q_free     (q_free),
        .o_push       (push)
    );

    b64d_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_free      (q_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_item      (item)
    );

    assign o_out_byte    = item.out_byte;
    assign o_is_status   = item.is_status;
    assign o_status_code = item.status_code;
    assign o_last        = item.last;

endmodule

// ===== design/b64d_core.sv =====
// Decode core: input register, group state and result generation per beat.
// Depends on b64d_pkg; feeds b64d_outq.
module b64d_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [7:0]                i_char_code,
    input  logic                      i_end_marker,
    input  logic [b64d_pkg::Q_W-1:0]  i_q_free,
    output b64d_pkg::t_push           o_push
);
    import b64d_pkg::*;

    // Input register
    logic             r_in_valid;
    logic [7:0]       r_char;
    logic             r_end;

    // Decode state
    logic [1:0]       r_pos;
    logic [23:0]      r_acc;
    logic [1:0]       r_pad;
    logic             r_held_v;
    logic [23:0]      r_held;
    logic [1:0]       r_held_pad;
    logic [CNT_W-1:0] r_cnt;
    logic             r_err;

    t_sextet          sx;
    logic             is_ws;
    logic             is_pad;
    logic             counted;
    logic             illegal;
    logic             err_next;
    logic             bad_end;
    logic [23:0]      acc_shift;
    logic [1:0]       pad_next;
    logic [Q_W-1:0]   n_bytes;
    logic [Q_W-1:0]   n_items;
    logic             adv;
    t_item            status_item;

    // Classify the registered character
    always_comb begin
        sx        = sextet_of(r_char);
        is_ws     = (r_char == CHAR_SPACE) || (r_char >= CHAR_TAB && r_char <= CHAR_CR);
        is_pad    = (r_char == CHAR_PAD);
        counted   = !r_end && !is_ws && (r_cnt < CNT_W'(MAX_CHARS));
        illegal   = !sx.ok && !(is_pad && r_pos[1]);
        err_next  = r_err || illegal;
        acc_shift = {r_acc[17:0], sx.ok ? sx.val : 6'd0};
        pad_next  = r_pad + {1'b0, is_pad && r_pos[1]};
        bad_end   = r_err || (r_cnt == '0) || (r_cnt[1:0] != 2'b00);
    end

    // Work out how many bytes and results this beat releases
    always_comb begin
        n_bytes = '0;
        n_items = '0;
        if (r_end) begin
            if (!bad_end && r_held_v) begin
                n_bytes = (r_held_pad[1]) ? Q_W'(1) : Q_W'(3) - Q_W'(r_held_pad);
            end
            n_items = n_bytes + Q_W'(1);
        end else if (counted && (r_pos == 2'd0) && r_held_v && !err_next) begin
            n_bytes = Q_W'(3);
            n_items = Q_W'(3);
        end
    end

    // Build the result beats: held bytes first, then the status
    always_comb begin
        status_item.out_byte    = 8'h00;
        status_item.is_status   = 1'b1;
        status_item.status_code = bad_end ? STATUS_INVALID : STATUS_OK;
        status_item.last        = 1'b1;
        o_push.valid            = adv;
        o_push.n                = n_items;
        for (int k = 0; k < QDEPTH; k++) begin
            o_push.items[k] = status_item;
        end
        // At most three bytes come ahead of the status
        for (int k = 0; k < QDEPTH - 1; k++) begin
            if (Q_W'(k) < n_bytes) begin
                o_push.items[k].out_byte    = r_held[23 - 8*k -: 8];
                o_push.items[k].is_status   = 1'b0;
                o_push.items[k].status_code = STATUS_OK;
                o_push.items[k].last        = 1'b0;
            end
        end
    end

    assign adv          = r_in_valid && (i_q_free >= n_items);
    assign o_in_ready   = !r_in_valid || adv;

    // Hold the accepted beat until the queue has room for its results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_char <= i_char_code;
            r_end  <= i_end_marker;
        end
    end

    // Advance the group state; clear it all at the end marker
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_acc      <= '0;
            r_pad      <= '0;
            r_held_v   <= 1'b0;
            r_held     <= '0;
            r_held_pad <= '0;
            r_cnt      <= '0;
            r_err      <= 1'b0;
        end else if (adv) begin
            if (r_end) begin
                r_pos      <= '0;
                r_acc      <= '0;
                r_pad      <= '0;
                r_held_v   <= 1'b0;
                r_held     <= '0;
                r_held_pad <= '0;
                r_cnt      <= '0;
                r_err      <= 1'b0;
            end else if (counted) begin
                r_cnt <= r_cnt + CNT_W'(1);
                r_err <= err_next;
                if (r_pos == 2'd3) begin
                    r_held     <= acc_shift;
                    r_held_pad <= pad_next;
                    r_held_v   <= 1'b1;
                    r_acc      <= '0;
                    r_pad      <= '0;
                    r_pos      <= '0;
                end else begin
                    if (r_pos == 2'd0) begin
                        r_held_v <= 1'b0;
                    end
                    r_acc <= acc_shift;
                    r_pad <= pad_next;
                    r_pos <= r_pos + 2'd1;
                end
            end
        end
    end

endmodule

// ===== design/b64d_outq.sv =====
// Result queue: four slots that take a burst of results in one cycle and
// hand out one beat a cycle while the receiver is ready. Depends on b64d_pkg.
module b64d_outq (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  b64d_pkg::t_push           i_push,
    output logic [b64d_pkg::Q_W-1:0]  o_free,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output b64d_pkg::t_item           o_item
);
    import b64d_pkg::*;

    t_item [QDEPTH-1:0] r_slot;
    t_item [QDEPTH-1:0] n_slot;
    logic  [Q_W-1:0]    r_count;
    logic  [Q_W-1:0]    n_count;
    logic               pop;
    logic  [Q_W-1:0]    base;

    assign pop  = (r_count != '0) && i_out_ready;
    assign base = r_count - Q_W'(pop);

    // Shift out the head beat, then append the new burst behind what stays
    always_comb begin
        logic [Q_W-1:0] v_rel;
        n_slot  = r_slot;
        n_count = base + (i_push.valid ? i_push.n : '0);
        if (pop) begin
            for (int i = 0; i < QDEPTH - 1; i++) begin
                n_slot[i] = r_slot[i + 1];
            end
        end
        for (int i = 0; i < QDEPTH; i++) begin
            v_rel = Q_W'(i) - base;
            if (i_push.valid && (Q_W'(i) >= base) && (v_rel < i_push.n)) begin
                n_slot[i] = i_push.items[v_rel[IDX_W-1:0]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
        r_slot <= n_slot;
    end

    assign o_free      = Q_W'(QDEPTH) - r_count;
    assign o_out_valid = (r_count != '0);
    assign o_item      = r_slot[0];

endmodule

// ===== design/b64d_checker.sv =====
// Port-level checks for the base64 stream decoder, bound to the top level.
// Depends only on the top-level ports.
module b64d_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_out_byte,
    input logic       o_is_status,
    input logic       o_status_code,
    input logic       o_last
);

    // Reset empties the result queue
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat shown right after reset");

    // Only the status beat closes a text
    a_last_is_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last == o_is_status))
        else $error("last flag disagrees with status flag");

    // Byte beats carry no status code and a status beat carries no byte
    a_byte_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_is_status |-> !o_status_code)
        else $error("status code set on a byte beat");

    a_status_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_status |-> (o_out_byte == 8'h00))
        else $error("byte value on a status beat");

    // Hold a stalled beat
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_byte)
            && $stable(o_is_status) && $stable(o_status_code))
        else $error("stalled result beat changed");

endmodule

bind base64_stream_decoder_unit b64d_checker u_b64d_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_out_byte    (o_out_byte),
    .o_is_status   (o_is_status),
    .o_status_code (o_status_code),
    .o_last        (o_last)
);

// ===== tb/sv/base64_stream_decoder_unit_tb.sv =====
// Self-checking testbench for base64_stream_decoder_unit: directed texts, then
// random well-formed, broken and noise texts, checked beat by beat against a decoder
// model held in a small scoreboard class. Depends on b64d_pkg and the decoder RTL.
module base64_stream_decoder_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import b64d_pkg::*;

    localparam int ITEM_TARGET = 350;
    localparam int STALL_LIMIT = 1000;
    localparam int TAIL_CYCLES = 4;

    typedef logic [7:0] char_q_t[$];

    // Decoder model and store of expected result beats
    class decode_scoreboard;
        t_item       expected_beats[$];
        int unsigned failures;

        logic [1:0]  grp_pos;
        logic [23:0] grp_bits;
        logic [1:0]  grp_pads;
        bit          held;
        logic [23:0] held_bits;
        logic [1:0]  held_pads;
        int unsigned counted;
        bit          bad_char;

        function new();
            failures = 0;
            clear_text();
        endfunction

        // Drop all text state, as after reset or an end marker
        function void clear_text();
            grp_pos   = '0;
            grp_bits  = '0;
            grp_pads  = '0;
            held      = 1'b0;
            held_bits = '0;
            held_pads = '0;
            counted   = 0;
            bad_char  = 1'b0;
        endfunction

        function int unsigned pending();
            return expected_beats.size();
        endfunction

        // Queue the leading nbytes of a decoded triple
        function void push_triple(logic [23:0] bits, int unsigned nbytes);
            t_item b;
            for (int unsigned i = 0; i < nbytes; i++) begin
                b.out_byte    = 8'(bits >> (16 - 8 * i));
                b.is_status   = 1'b0;
                b.status_code = STATUS_OK;
                b.last        = 1'b0;
                expected_beats.push_back(b);
            end
        endfunction

        // Advance the model by one accepted input beat
        function void note_input(logic [7:0] c, logic endm);
            t_item      st;
            bit         text_bad;
            logic [5:0] six;
            int unsigned trim;
            if (endm) begin
                text_bad = bad_char || counted == 0 || (counted % 4) != 0;
                if (!text_bad && held) begin
                    trim = (held_pads > 2) ? 2 : held_pads;
                    push_triple(held_bits, 3 - trim);
                end
                st.out_byte    = 8'h00;
                st.is_status   = 1'b1;
                st.status_code = text_bad ? STATUS_INVALID : STATUS_OK;
                st.last        = 1'b1;
                expected_beats.push_back(st);
                clear_text();
                return;
            end
            // Skip whitespace and anything past the length limit
            if (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR)) return;
            if (counted >= MAX_CHARS) return;
            counted++;

            six = '0;
            if (c >= 8'h41 && c <= 8'h5A) six = 6'(c - 8'h41);
            else if (c >= 8'h61 && c <= 8'h7A) six = 6'(c - 8'h61 + 26);
            else if (c >= 8'h30 && c <= 8'h39) six = 6'(c - 8'h30 + 52);
            else if (c == 8'h2B) six = 6'd62;
            else if (c == 8'h2F) six = 6'd63;
            else if (c == CHAR_PAD && grp_pos >= 2) grp_pads = grp_pads + 2'd1;
            else bad_char = 1'b1;

            // A new group releases the held one, unless the text has gone bad
            if (grp_pos == 2'd0 && held) begin
                if (!bad_char) push_triple(held_bits, 3);
                held = 1'b0;
            end

            grp_bits = {grp_bits[17:0], six};
            if (grp_pos == 2'd3) begin
                held_bits = grp_bits;
                held_pads = grp_pads;
                held      = 1'b1;
                grp_bits  = '0;
                grp_pads  = '0;
                grp_pos   = '0;
            end else begin
                grp_pos = grp_pos + 2'd1;
            end
        endfunction

        // Compare one result beat with the oldest expectation
        function void check_result(t_item got);
            t_item want;
            if (expected_beats.size() == 0) begin
                $error("unexpected result beat: out_byte %0h is_status %0b %s %0b last %0b",
                       got.out_byte, got.is_status, "status_code", got.status_code,
                       got.last);
                failures++;
                return;
            end
            want = expected_beats.pop_front();
            if (got != want) begin
                failures++;
                if (got.out_byte != want.out_byte)
                    $error("out_byte: expected %0h, actual %0h", want.out_byte, got.out_byte);
                if (got.is_status != want.is_status)
                    $error("is_status: expected %0b, actual %0b", want.is_status, got.is_status);
                if (got.status_code != want.status_code)
                    $error("status_code: expected %0b, actual %0b",
                           want.status_code, got.status_code);
                if (got.last != want.last)
                    $error("last: expected %0b, actual %0b", want.last, got.last);
            end
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [7:0] i_char_code;
    logic       i_end_marker;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [7:0] o_out_byte;
    logic       o_is_status;
    logic       o_status_code;
    logic       o_last;

    decode_scoreboard sb = new();
    bit               idle_off;
    int unsigned      items_sent;
    int unsigned      stall_cycles;

    base64_stream_decoder_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_char_code   (i_char_code),
        .i_end_marker  (i_end_marker),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_byte    (o_out_byte),
        .o_is_status   (o_is_status),
        .o_status_code (o_status_code),
        .o_last        (o_last)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Map a 6-bit index to its alphabet character
    function automatic logic [7:0] alpha_char(int unsigned idx);
        if (idx < 26) return 8'(8'h41 + idx);
        if (idx < 52) return 8'(8'h61 + idx - 26);
        if (idx < 62) return 8'(8'h30 + idx - 52);
        if (idx == 62) return 8'h2B;
        return 8'h2F;
    endfunction

    // Well-formed text of whole groups; padding mostly in the final group
    function automatic char_q_t build_text(int unsigned groups);
        char_q_t     text;
        int unsigned pads;
        for (int unsigned g = 0; g < groups; g++) begin
            for (int p = 0; p < 4; p++) text.push_back(alpha_char($urandom_range(0, 63)));
            // 1: last place, 2: last two places, 3: third place only
            if (g == groups - 1) pads = $urandom_range(0, 3);
            else pads = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
            if (pads == 1 || pads == 2) text[text.size() - 1] = CHAR_PAD;
            if (pads >= 2) text[text.size() - 2] = CHAR_PAD;
        end
        return text;
    endfunction

    // Offer one input beat after a random gap; return at the next falling edge
    task automatic send_beat(input logic [7:0] c, input logic endm);
        int gap;
        gap = idle_off ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_char_code  <= c;
        i_end_marker <= endm;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(c, endm);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Send a text with optional random whitespace, then its end marker
    task automatic send_text(input char_q_t text, input int unsigned ws_pct);
        int unsigned ws;
        foreach (text[i]) begin
            if ($urandom_range(0, 99) < ws_pct) begin
                ws = $urandom_range(0, 5);
                send_beat((ws == 5) ? CHAR_SPACE : 8'(CHAR_TAB + ws), 1'b0);
            end
            send_beat(text[i], 1'b0);
        end
        send_beat(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // Take one result beat after a random stall
    task automatic take_result();
        int    gap;
        t_item got;
        gap = idle_off ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_out_ready <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_out_ready <= 1'b1;
        do @(posedge i_clk); while (!o_out_valid);
        got.out_byte    = o_out_byte;
        got.is_status   = o_is_status;
        got.status_code = o_status_code;
        got.last        = o_last;
        sb.check_result(got);
        @(negedge i_clk);
    endtask

    initial begin
        wait (i_rst_n === 1'b1);
        forever take_result();
    end

    // Watchdog: end the run when no beat moves for too long
    initial begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) stall_cycles = 0;
            else stall_cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    initial begin
        char_q_t     text;
        int unsigned kind;
        int unsigned texts_done;
        int unsigned idx;

        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_char_code  = 8'h00;
        i_end_marker = 1'b0;
        i_out_ready  = 1'b0;
        idle_off     = 1'b0;
        items_sent   = 0;
        texts_done   = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty text
        text = {};
        send_text(text, 0);
        // "/+=9" CR LF "Az0=": pad inside a non-final group, final pad trims one byte
        text = {8'h2F, 8'h2B, CHAR_PAD, 8'h39, CHAR_CR, 8'h0A, 8'h41, 8'h7A, 8'h30, CHAR_PAD};
        send_text(text, 0);
        // Pad in first place, NUL and 0xFF, VT: illegal and short
        text = {CHAR_PAD, 8'h00, 8'hFF, 8'h0B};
        send_text(text, 0);
        // "Q" space "=xy" FF: pad in second place on a whole group
        text = {8'h51, CHAR_SPACE, CHAR_PAD, 8'h78, 8'h79, 8'h0C};
        send_text(text, 0);

        // Overlong text: characters past the limit are dropped
        text = build_text(MAX_CHARS / 4 + 3);
        send_text(text, 5);

        while (items_sent < ITEM_TARGET) begin
            idle_off = ($urandom_range(0, 3) == 0);
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                text = build_text($urandom_range(1, 6));
            end else if (kind < 85) begin
                // Break a well-formed text in one place
                text = build_text($urandom_range(1, 4));
                idx  = $urandom_range(0, text.size() - 1);
                case ($urandom_range(0, 2))
                    0: text[idx] = 8'($urandom_range(0, 255));
                    1: text.delete(idx);
                    default: text.insert(idx, CHAR_PAD);
                endcase
            end else begin
                text = {};
                repeat ($urandom_range(0, 8)) text.push_back(8'($urandom_range(0, 255)));
            end
            send_text(text, (kind < 85) ? 10 : 0);
            texts_done++;
            // Hold off once until every expected beat has come
            if (texts_done == 1) begin
                i_in_valid <= 1'b0;
                while (sb.pending() != 0) @(negedge i_clk);
            end
        end

        i_in_valid <= 1'b0;
        idle_off = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.failures == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/b64d_pkg.sv
design/b64d_core.sv
design/b64d_outq.sv
design/base64_stream_decoder_unit.sv
design/b64d_checker.sv
tb/sv/base64_stream_decoder_unit_tb.sv
